/* src/srp_pkg.sv */
package srp_pkg;

    // Characters recognized by the parser
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_S       = 8'h53;
    localparam logic [7:0] CHAR_0       = 8'h30;
    localparam logic [7:0] CHAR_1       = 8'h31;
    localparam logic [7:0] CHAR_9       = 8'h39;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F = 8'h46;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F = 8'h66;

    // Smallest legal byte count: two address bytes and the checksum
    localparam logic [7:0] MIN_COUNT    = 8'd3;
    localparam logic [7:0] SUM_GOOD     = 8'hFF;

    // Depth of the token queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Character positions within a record line
    localparam logic [3:0] POS_START     = 4'd0;
    localparam logic [3:0] POS_TYPE      = 4'd1;
    localparam logic [3:0] POS_COUNT_HI  = 4'd2;
    localparam logic [3:0] POS_COUNT_LO  = 4'd3;
    localparam logic [3:0] POS_ADDR_H_LO = 4'd5;
    localparam logic [3:0] POS_ADDR_L_LO = 4'd7;
    localparam logic [3:0] POS_BODY_HI   = 4'd8;

    typedef enum logic [2:0] {
        KIND_WRITE  = 3'd0,
        KIND_OK     = 3'd1,
        KIND_BADSUM = 3'd2,
        KIND_REJECT = 3'd3,
        KIND_ABORT  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        TYPE_S0  = 2'd0,
        TYPE_S1  = 2'd1,
        TYPE_S9  = 2'd2,
        TYPE_BAD = 2'd3
    } rec_type_t;

    // Classified character handed from front to back
    typedef struct packed {
        logic       newline;
        logic       hex_ok;
        logic [3:0] hex;
        logic       is_s;
        rec_type_t  digit_type;
    } token_t;

    typedef struct packed {
        kind_t       result_kind;
        logic [1:0]  record_type;
        logic [15:0] address;
        logic [7:0]  data;
    } result_t;

endpackage

/* src/srp_char_if.sv */
interface srp_char_if;
    import srp_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] character;

    modport source (output valid, output character, input ready);
    modport sink   (input valid, input character, output ready);

endinterface

/* src/srp_result_if.sv */
interface srp_result_if;
    import srp_pkg::*;

    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [1:0]  record_type;
    logic [15:0] address;
    logic [7:0]  data;

    modport source (output valid, output result_kind, output record_type,
                    output address, output data, input ready);
    modport sink   (input valid, input result_kind, input record_type,
                    input address, input data, output ready);

endinterface

/* src/srecord_loader_parser_top.sv */
// S-record loader parser (S0, S1, S9).
// stream: one ASCII character per transaction; a newline ends a record.
// result: at most one transaction per character: a memory write for each
//   S1 data byte, a record done (ok or checksum mismatch) after the
//   checksum, a reject for a bad type or count, or an abort for a non-hex
//   digit or an early newline. After an abort no further results appear
//   until reset.
// Throughput: one character per cycle unless a held result stalls it. A
//   classify register in front, a two-entry token queue and a parser with
//   an output register behind it each hand over a transaction every cycle
//   unless stalled. A character passes the classify register, the queue
//   and the output register in that order before its result is offered.
// Reset: clears the parser to the start of a record and empties the queue.
// Stall: while result is held, the output register keeps its transaction,
//   the queue and the front register fill, and stream.ready drops once
//   both are full; nothing is lost.
module srecord_loader_parser_top
    import srp_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 36
)
(
    input  logic          clk,
    input  logic          rst_n,
    srp_char_if.sink      stream,
    srp_result_if.source  result
);

    logic    front_valid;
    logic    front_ready;
    token_t  front_tok;
    logic    queue_valid;
    logic    queue_ready;
    token_t  queue_tok;
    result_t res;

    srp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .stream    (stream),
        .tok_valid (front_valid),
        .tok_ready (front_ready),
        .tok       (front_tok)
    );

    srp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_tok    (front_tok),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_tok   (queue_tok)
    );

    srp_back #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (queue_valid),
        .tok_ready (queue_ready),
        .tok       (queue_tok),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res       (res)
    );

    // Drive the result channel payload
    assign result.result_kind = res.result_kind;
    assign result.record_type = res.record_type;
    assign result.address     = res.address;
    assign result.data        = res.data;

endmodule

/* src/srp_front.sv */
module srp_front
    import srp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    srp_char_if.sink   stream,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok
);

    logic   valid_reg;
    logic   valid_next;
    token_t tok_reg;
    token_t tok_next;
    logic   take;

    // Accept while the stage is empty or draining into the queue
    assign stream.ready = !valid_reg || tok_ready;
    assign take         = stream.valid && stream.ready;

    // Classify the incoming character
    always_comb
    begin
        logic [7:0] c;
        c = stream.character;
        tok_next.newline = (c == CHAR_NEWLINE);
        tok_next.is_s    = (c == CHAR_S);
        tok_next.hex_ok  = 1'b1;
        tok_next.hex     = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            tok_next.hex = 4'(c - CHAR_0);
        end
        else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            tok_next.hex = 4'(c - CHAR_UPPER_A + 8'd10);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            tok_next.hex = 4'(c - CHAR_LOWER_A + 8'd10);
        end
        else
        begin
            tok_next.hex_ok = 1'b0;
        end
        case (c)
            CHAR_0:  tok_next.digit_type = TYPE_S0;
            CHAR_1:  tok_next.digit_type = TYPE_S1;
            CHAR_9:  tok_next.digit_type = TYPE_S9;
            default: tok_next.digit_type = TYPE_BAD;
        endcase
    end

    // Hold the stage until the queue takes it
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = valid_reg;
    assign tok       = tok_reg;

endmodule

/* src/srp_queue.sv */
module srp_queue
    import srp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_tok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    token_t           entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_tok   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_tok;
        end
    end

endmodule

/* src/srp_back.sv */
module srp_back
    import srp_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = 36
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    tok_valid,
    output logic    tok_ready,
    input  token_t  tok,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int OFFSET_W = (MAX_RECORD_BYTES > 4) ? $clog2(MAX_RECORD_BYTES - 3) : 1;
    localparam logic [7:0] MAX_COUNT = 8'(MAX_RECORD_BYTES);

    logic [3:0]          pos_reg,    pos_next;
    rec_type_t           type_reg,   type_next;
    logic [7:0]          count_reg,  count_next;
    logic [15:0]         addr_reg,   addr_next;
    logic [7:0]          sum_reg,    sum_next;
    logic [3:0]          pend_reg,   pend_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic                skip_reg,   skip_next;
    logic                halted_reg, halted_next;
    logic                out_valid_reg, out_valid_next;
    result_t             out_reg,    out_next;
    logic                take;
    logic                emit;
    logic [7:0]          byte_val;
    logic [7:0]          sum_plus;
    logic [15:0]         addr_full;

    function automatic logic [1:0] report_type(rec_type_t t);
        return (t == TYPE_BAD) ? 2'd0 : 2'(t);
    endfunction

    // Take a token whenever the output slot is free or draining
    assign tok_ready = !out_valid_reg || res_ready;
    assign take      = tok_valid && tok_ready;
    assign byte_val  = {pend_reg, tok.hex};
    assign sum_plus  = sum_reg + byte_val;
    assign addr_full = {addr_reg[15:8], byte_val};

    // Parse one token and form its result
    always_comb
    begin
        pos_next    = pos_reg;
        type_next   = type_reg;
        count_next  = count_reg;
        addr_next   = addr_reg;
        sum_next    = sum_reg;
        pend_next   = pend_reg;
        offset_next = offset_reg;
        skip_next   = skip_reg;
        halted_next = halted_reg;
        emit        = 1'b0;
        out_next.result_kind = KIND_ABORT;
        out_next.record_type = 2'd0;
        out_next.address     = 16'd0;
        out_next.data        = 8'd0;
        if (take && !halted_reg)
        begin
            if (skip_reg)
            begin
                if (tok.newline)
                begin
                    skip_next = 1'b0;
                    pos_next  = POS_START;
                end
            end
            else if (tok.newline)
            begin
                halted_next = 1'b1;
                emit        = 1'b1;
            end
            else
            begin
                case (pos_reg)
                    POS_START:
                    begin
                        type_next = tok.is_s ? TYPE_S0 : TYPE_BAD;
                        pos_next  = POS_TYPE;
                    end
                    POS_TYPE:
                    begin
                        if (type_reg != TYPE_BAD)
                        begin
                            type_next = tok.digit_type;
                        end
                        pos_next = POS_COUNT_HI;
                    end
                    default:
                    begin
                        if (!tok.hex_ok)
                        begin
                            halted_next = 1'b1;
                            emit        = 1'b1;
                        end
                        else if (!pos_reg[0])
                        begin
                            pend_next = tok.hex;
                            pos_next  = pos_reg + 4'd1;
                        end
                        else
                        begin
                            case (pos_reg)
                                POS_COUNT_LO:
                                begin
                                    count_next = byte_val;
                                    sum_next   = byte_val;
                                    pos_next   = pos_reg + 4'd1;
                                end
                                POS_ADDR_H_LO:
                                begin
                                    addr_next = {byte_val, 8'd0};
                                    sum_next  = sum_plus;
                                    pos_next  = pos_reg + 4'd1;
                                end
                                POS_ADDR_L_LO:
                                begin
                                    addr_next = addr_full;
                                    sum_next  = sum_plus;
                                    if (type_reg == TYPE_BAD || count_reg < MIN_COUNT ||
                                        count_reg > MAX_COUNT)
                                    begin
                                        skip_next = 1'b1;
                                        emit      = 1'b1;
                                        out_next.result_kind = KIND_REJECT;
                                        out_next.record_type = report_type(type_reg);
                                        out_next.address     = addr_full;
                                    end
                                    else
                                    begin
                                        count_next  = count_reg - MIN_COUNT;
                                        offset_next = '0;
                                        pos_next    = POS_BODY_HI;
                                    end
                                end
                                default:
                                begin
                                    pos_next = POS_BODY_HI;
                                    sum_next = sum_plus;
                                    if (count_reg != 8'd0)
                                    begin
                                        count_next = count_reg - 8'd1;
                                        if (type_reg == TYPE_S1)
                                        begin
                                            offset_next = offset_reg + 1'b1;
                                            emit        = 1'b1;
                                            out_next.result_kind = KIND_WRITE;
                                            out_next.record_type = report_type(type_reg);
                                            out_next.address     =
                                                addr_reg + 16'(offset_reg);
                                            out_next.data        = byte_val;
                                        end
                                    end
                                    else
                                    begin
                                        skip_next = 1'b1;
                                        emit      = 1'b1;
                                        out_next.result_kind =
                                            (sum_plus == SUM_GOOD) ? KIND_OK : KIND_BADSUM;
                                        out_next.record_type = report_type(type_reg);
                                        out_next.address     = addr_reg;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
        end
    end

    // Hold the result until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_START;
            type_reg      <= TYPE_S0;
            count_reg     <= 8'd0;
            addr_reg      <= 16'd0;
            sum_reg       <= 8'd0;
            pend_reg      <= 4'd0;
            offset_reg    <= '0;
            skip_reg      <= 1'b0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            type_reg      <= type_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            sum_reg       <= sum_next;
            pend_reg      <= pend_next;
            offset_reg    <= offset_next;
            skip_reg      <= skip_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

/* sim/srecord_loader_parser_top_tb.sv */
`timescale 1ns / 100ps

module srecord_loader_parser_top_tb;
    import srp_pkg::*;

    localparam int MAX_RECORD_BYTES = 36;
    localparam int RANDOM_CHARS     = 950;
    localparam int DRAIN_CYCLES     = 20;

    logic clk;
    logic rst_n;

    srp_char_if   char_bus ();
    srp_result_if result_bus ();

    srecord_loader_parser_top #(
        .MAX_RECORD_BYTES(MAX_RECORD_BYTES)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (char_bus),
        .result (result_bus)
    );

    // Loader state as the parser should hold it
    logic [6:0]  parse_pos;
    rec_type_t   parse_type;
    logic [7:0]  bytes_left;
    logic [15:0] rec_addr;
    logic [7:0]  rec_sum;
    logic [3:0]  high_nibble;
    logic [7:0]  write_offset;
    logic        skipping_line;
    logic        load_halted;

    result_t     loader_events_due[$];
    logic [7:0]  line_buf[$];
    logic [7:0]  payload_buf[$];

    logic        idle_on;
    int          mismatches;
    int          chars_sent;
    int          records_sent;
    int          kinds_seen[5];
    result_t     due_event;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    // Queue one expected result; an invalid type is reported as S0
    function automatic void push_due(input kind_t kind, input rec_type_t rtype,
                                     input logic [15:0] addr, input logic [7:0] data);
        result_t r;
        r.result_kind = kind;
        r.record_type = (rtype == TYPE_BAD) ? TYPE_S0 : rtype;
        r.address     = addr;
        r.data        = data;
        loader_events_due.push_back(r);
    endfunction

    function automatic logic hex_nibble(input logic [7:0] c, output logic [3:0] nib);
        nib = 4'd0;
        if (c >= CHAR_0 && c <= CHAR_9)
        begin
            nib = 4'(c - CHAR_0);
            return 1'b1;
        end
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
        begin
            nib = 4'(c - CHAR_UPPER_A + 8'd10);
            return 1'b1;
        end
        if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            nib = 4'(c - CHAR_LOWER_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the loader by one accepted character
    function automatic void parse_stream_char(input logic [7:0] c);
        logic [3:0] nib;
        logic [7:0] b;
        if (load_halted)
            return;
        if (skipping_line)
        begin
            if (c == CHAR_NEWLINE)
            begin
                skipping_line = 1'b0;
                parse_pos     = 7'(POS_START);
            end
            return;
        end
        if (c == CHAR_NEWLINE)
        begin
            load_halted = 1'b1;
            push_due(KIND_ABORT, TYPE_S0, 16'h0000, 8'h00);
            return;
        end
        if (parse_pos == POS_START)
        begin
            parse_type = (c == CHAR_S) ? TYPE_S0 : TYPE_BAD;
            parse_pos  = 7'(POS_TYPE);
            return;
        end
        if (parse_pos == POS_TYPE)
        begin
            if (parse_type != TYPE_BAD)
            begin
                if (c == CHAR_0)
                    parse_type = TYPE_S0;
                else if (c == CHAR_1)
                    parse_type = TYPE_S1;
                else if (c == CHAR_9)
                    parse_type = TYPE_S9;
                else
                    parse_type = TYPE_BAD;
            end
            parse_pos = 7'(POS_COUNT_HI);
            return;
        end
        if (!hex_nibble(c, nib))
        begin
            load_halted = 1'b1;
            push_due(KIND_ABORT, TYPE_S0, 16'h0000, 8'h00);
            return;
        end
        // Hold the high digit until the low one completes the byte
        if (!parse_pos[0])
        begin
            high_nibble = nib;
            parse_pos   = parse_pos + 7'd1;
            return;
        end
        b = {high_nibble, nib};
        case (parse_pos)
            POS_COUNT_LO:
            begin
                bytes_left = b;
                rec_sum    = b;
                parse_pos  = parse_pos + 7'd1;
            end
            POS_ADDR_H_LO:
            begin
                rec_addr  = {b, 8'h00};
                rec_sum   = rec_sum + b;
                parse_pos = parse_pos + 7'd1;
            end
            POS_ADDR_L_LO:
            begin
                rec_addr[7:0] = b;
                rec_sum       = rec_sum + b;
                if (parse_type == TYPE_BAD || bytes_left < MIN_COUNT ||
                    bytes_left > MAX_RECORD_BYTES)
                begin
                    skipping_line = 1'b1;
                    push_due(KIND_REJECT, parse_type, rec_addr, 8'h00);
                end
                else
                begin
                    bytes_left   = bytes_left - MIN_COUNT;
                    write_offset = 8'd0;
                    parse_pos    = 7'(POS_BODY_HI);
                end
            end
            default:
            begin
                parse_pos = 7'(POS_BODY_HI);
                rec_sum   = rec_sum + b;
                if (bytes_left > 0)
                begin
                    bytes_left = bytes_left - 8'd1;
                    if (parse_type == TYPE_S1)
                    begin
                        push_due(KIND_WRITE, parse_type, rec_addr + 16'(write_offset), b);
                        write_offset = write_offset + 8'd1;
                    end
                end
                else
                begin
                    skipping_line = 1'b1;
                    push_due((rec_sum == SUM_GOOD) ? KIND_OK : KIND_BADSUM,
                             parse_type, rec_addr, 8'h00);
                end
            end
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic lower;
        lower = 1'($urandom_range(0, 1));
        if (nib < 4'd10)
            return CHAR_0 + 8'(nib);
        return (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(nib - 4'd10);
    endfunction

    function automatic void push_hex_byte(input logic [7:0] b);
        line_buf.push_back(hex_char(b[7:4]));
        line_buf.push_back(hex_char(b[3:0]));
    endfunction

    function automatic logic [7:0] random_non_newline();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CHAR_NEWLINE);
        return c;
    endfunction

    function automatic void fill_payload(input int n);
        payload_buf.delete();
        repeat (n)
            payload_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    // Lay out one record line from payload_buf, checksum, trailer_len random characters, then newline
    function automatic void build_record(input logic [7:0] first, input logic [7:0] type_ch,
                                         input logic [7:0] count, input logic [15:0] addr,
                                         input logic corrupt, input int trailer_len);
        logic [7:0] chk;
        line_buf.delete();
        line_buf.push_back(first);
        line_buf.push_back(type_ch);
        push_hex_byte(count);
        push_hex_byte(addr[15:8]);
        push_hex_byte(addr[7:0]);
        chk = count + addr[15:8] + addr[7:0];
        foreach (payload_buf[i])
        begin
            push_hex_byte(payload_buf[i]);
            chk = chk + payload_buf[i];
        end
        chk = ~chk;
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        push_hex_byte(chk);
        repeat (trailer_len)
            line_buf.push_back(random_non_newline());
        line_buf.push_back(CHAR_NEWLINE);
    endfunction

    // Offer one character and hold it until the parser takes it
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.character <= c;
        do
            @(posedge clk);
        while (char_bus.ready !== 1'b1);
        parse_stream_char(c);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_char(line_buf[i]);
        records_sent++;
    endtask

    task automatic send_record(input logic [7:0] first, input logic [7:0] type_ch,
                               input logic [7:0] count, input logic [15:0] addr,
                               input logic corrupt, input int trailer_len);
        build_record(first, type_ch, count, addr, corrupt, trailer_len);
        send_line();
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic wait_loader_idle();
        char_bus.valid <= 1'b0;
        while (loader_events_due.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    task automatic test_valid_records();
        payload_buf.delete();
        send_record(CHAR_S, CHAR_0, 8'd3, 16'h0000, 1'b0, 0);
        payload_buf = '{8'h00, 8'hFF};
        send_record(CHAR_S, CHAR_1, 8'd5, 16'hFFFF, 1'b0, 0);
        payload_buf = '{8'hA5};
        send_record(CHAR_S, CHAR_1, 8'd4, 16'h1234, 1'b0, 2);
        payload_buf.delete();
        send_record(CHAR_S, CHAR_9, 8'd3, 16'h8000, 1'b0, 0);
    endtask

    task automatic test_checksum_mismatch();
        payload_buf = '{8'h5A};
        send_record(CHAR_S, CHAR_1, 8'd4, 16'h00FF, 1'b1, 0);
        payload_buf.delete();
        send_record(CHAR_S, CHAR_9, 8'd3, 16'hABCD, 1'b1, 1);
    endtask

    task automatic test_rejected_records();
        payload_buf = '{8'h11};
        send_record(8'h58, CHAR_1, 8'd4, 16'h0100, 1'b0, 2);
        send_record(CHAR_S, 8'h32, 8'd4, 16'h0200, 1'b0, 0);
        send_record(CHAR_S, CHAR_1, 8'd2, 16'h0300, 1'b0, 0);
        send_record(CHAR_S, CHAR_1, 8'd37, 16'h0400, 1'b0, 0);
        send_record(CHAR_S, CHAR_1, 8'hFF, 16'hFFFF, 1'b0, 0);
        send_record(CHAR_S, CHAR_0, 8'd0, 16'h0000, 1'b0, 1);
    endtask

    task automatic test_longest_record();
        fill_payload(MAX_RECORD_BYTES - 3);
        send_record(CHAR_S, CHAR_1, 8'(MAX_RECORD_BYTES), 16'hFFF0, 1'b0, 3);
    endtask

    // Mostly well-formed records with random content, some rejects and bad sums
    task automatic random_record();
        int pick;
        int n;
        logic [7:0] cnt;
        logic [7:0] first;
        logic [7:0] type_ch;
        logic [15:0] addr;
        pick  = $urandom_range(0, 99);
        n     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_RECORD_BYTES - 3)
                                            : $urandom_range(0, 8);
        addr  = ($urandom_range(0, 9) == 0) ? 16'hFFFF - 16'($urandom_range(0, 40))
                                            : 16'($urandom_range(0, 16'hFFFF));
        cnt   = 8'(n + 3);
        first = CHAR_S;
        if (pick < 60)
            type_ch = CHAR_1;
        else if (pick < 70)
            type_ch = CHAR_0;
        else if (pick < 78)
            type_ch = CHAR_9;
        else
        begin
            type_ch = random_non_newline();
            case ($urandom_range(0, 2))
                0: first = random_non_newline();
                1: ;
                default:
                begin
                    type_ch = ($urandom_range(0, 1) == 0) ? CHAR_1 : CHAR_9;
                    cnt = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                                      : 8'($urandom_range(37, 255));
                    n   = $urandom_range(0, 6);
                end
            endcase
        end
        fill_payload(n);
        send_record(first, type_ch, cnt, addr, $urandom_range(0, 7) == 0,
                    ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4));
    endtask

    task automatic test_random_stream();
        int start;
        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            random_record();
        end
        idle_on = 1'b1;
    endtask

    // Abort the load by an empty line, an early newline or a non-hex digit
    task automatic test_load_abort();
        int variant;
        int cut;
        logic [7:0] bad;
        logic [3:0] nib;
        variant = $urandom_range(0, 2);
        fill_payload($urandom_range(0, 4));
        build_record(CHAR_S, CHAR_1, 8'(payload_buf.size() + 3),
                     16'($urandom_range(0, 16'hFFFF)), 1'b0, 0);
        case (variant)
            0: cut = 0;
            1: cut = $urandom_range(1, line_buf.size() - 2);
            default: cut = $urandom_range(2, line_buf.size() - 2);
        endcase
        while (line_buf.size() > cut)
            void'(line_buf.pop_back());
        if (variant == 2)
        begin
            do
                bad = 8'($urandom_range(0, 255));
            while (hex_nibble(bad, nib) || bad == CHAR_NEWLINE);
            line_buf.push_back(bad);
        end
        else
            line_buf.push_back(CHAR_NEWLINE);
        send_line();

        // Nothing may come out after the abort
        fill_payload(2);
        send_record(CHAR_S, CHAR_1, 8'd5, 16'h2000, 1'b0, 0);
        repeat (8)
            send_char(8'($urandom_range(0, 255)));
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            if (result_bus.result_kind < 3'd5)
                kinds_seen[result_bus.result_kind]++;
            if (loader_events_due.size() == 0)
            begin
                $display("%0t: result expected none, got kind %0d addr %h data %h", $time,
                         result_bus.result_kind, result_bus.address, result_bus.data);
                mismatches++;
            end
            else
            begin
                due_event = loader_events_due.pop_front();
                check_field("result_kind", 16'(due_event.result_kind), 16'(result_bus.result_kind));
                check_field("record_type", 16'(due_event.record_type), 16'(result_bus.record_type));
                check_field("address", due_event.address, result_bus.address);
                check_field("data", 16'(due_event.data), 16'(result_bus.data));
            end
        end
    end

    // Hold result ready low for a random stall before each transaction while idle_on is set
    initial
    begin
        int stall;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_bus.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        char_bus.valid     = 1'b0;
        char_bus.character = 8'h00;
        idle_on            = 1'b1;
        mismatches         = 0;
        chars_sent         = 0;
        records_sent       = 0;
        parse_pos          = 7'(POS_START);
        parse_type         = TYPE_S0;
        bytes_left         = 8'd0;
        rec_addr           = 16'h0000;
        rec_sum            = 8'd0;
        high_nibble        = 4'd0;
        write_offset       = 8'd0;
        skipping_line      = 1'b0;
        load_halted        = 1'b0;
        foreach (kinds_seen[i])
            kinds_seen[i] = 0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_valid_records();
        test_checksum_mismatch();
        test_rejected_records();
        test_longest_record();
        wait_loader_idle();
        test_random_stream();
        test_load_abort();

        // Let the last results drain, then watch for stray ones
        wait_loader_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (loader_events_due.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     loader_events_due.size());
            mismatches++;
        end

        $display("Sent %0d characters in %0d record lines, ending with a load abort.",
                 chars_sent, records_sent);
        $display("Results: %0d writes, %0d ok, %0d bad checksum, %0d rejected, %0d aborted.",
                 kinds_seen[KIND_WRITE], kinds_seen[KIND_OK], kinds_seen[KIND_BADSUM],
                 kinds_seen[KIND_REJECT], kinds_seen[KIND_ABORT]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
